@@ rtl/tplc_pkg.sv @@
// tplc_pkg: shared types and constants of the two-point linear calibration block
// status codes and configuration register indexes
// no dependencies
package tplc_pkg;

  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;

  typedef enum logic [StatusW-1:0] {
    StOk         = 2'd0,
    StDegenerate = 2'd1,
    StRange      = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRawLo = 2'd0,
    CfgRefLo = 2'd1,
    CfgRawHi = 2'd2,
    CfgRefHi = 2'd3
  } cfg_idx_e;

endpackage

@@ rtl/tplc_in_if.sv @@
// tplc_in_if: valid/ready channel carrying one raw sample request
// no dependencies
interface tplc_in_if #(
  parameter int DataWidth = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

@@ rtl/tplc_out_if.sv @@
// tplc_out_if: valid/ready channel carrying one calibrated result request
// depends on tplc_pkg for the status code type
interface tplc_out_if #(
  parameter int DataWidth = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] calibrated_value;
  tplc_pkg::status_e           status;

  modport source (output valid, output calibrated_value, output status, input ready);
  modport sink   (input valid, input calibrated_value, input status, output ready);
endinterface

@@ rtl/two_point_linear_calibration_top.sv @@
// two_point_linear_calibration_top: pipelined two-point linear calibration
// depends on tplc_pkg, tplc_in_if and tplc_out_if
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------
//  in_i     | in  | valid / ready    | raw_sample
//  out_o    | out | valid / ready    | calibrated_value, status
//  cfg      | in  | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// one request per cycle while no result waits in the skid register; the divider
// resolves one quotient bit per pipeline stage
// reset clears valid bits and loads the calibration points (0,0) and (1,1)
// a skid register after the last stage takes a result refused by the sink,
// then the whole pipeline holds until the skid register drains
module two_point_linear_calibration_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tplc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]        cfg_data_i,
  tplc_in_if.sink                      in_i,
  tplc_out_if.source                   out_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;       // product width
  localparam int QW = 2 * W + 1;   // rounded numerator and quotient width
  localparam int SW = QW + 2;      // final signed sum width

  // configuration registers
  logic [W-1:0] raw_lo_q, ref_lo_q, raw_hi_q, ref_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_lo_q <= '0;
      ref_lo_q <= '0;
      raw_hi_q <= W'(1);
      ref_hi_q <= W'(1);
    end else if (cfg_we_i) begin
      unique case (tplc_pkg::cfg_idx_e'(cfg_idx_i))
        tplc_pkg::CfgRawLo: raw_lo_q <= cfg_data_i;
        tplc_pkg::CfgRefLo: ref_lo_q <= cfg_data_i;
        tplc_pkg::CfgRawHi: raw_hi_q <= cfg_data_i;
        tplc_pkg::CfgRefHi: ref_hi_q <= cfg_data_i;
      endcase
    end
  end

  // spans derived from the calibration points, as sign and magnitude
  logic [W:0]   raw_gap_d, ref_gap_d, raw_gap_n, ref_gap_n;
  logic [W-1:0] smag_q, rmag_q, half_q;
  logic         sraw_neg_q, sref_neg_q, degen_q;

  always_comb begin
    raw_gap_d = {raw_hi_q[W-1], raw_hi_q} - {raw_lo_q[W-1], raw_lo_q};
    ref_gap_d = {ref_hi_q[W-1], ref_hi_q} - {ref_lo_q[W-1], ref_lo_q};
    raw_gap_n = ~raw_gap_d + (W+1)'(1);
    ref_gap_n = ~ref_gap_d + (W+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smag_q     <= W'(1);
      rmag_q     <= W'(1);
      half_q     <= '0;
      sraw_neg_q <= 1'b0;
      sref_neg_q <= 1'b0;
      degen_q    <= 1'b0;
    end else begin
      smag_q     <= raw_gap_d[W] ? raw_gap_n[W-1:0] : raw_gap_d[W-1:0];
      rmag_q     <= ref_gap_d[W] ? ref_gap_n[W-1:0] : ref_gap_d[W-1:0];
      half_q     <= raw_gap_d[W] ? raw_gap_n[W:1] : raw_gap_d[W:1];
      sraw_neg_q <= raw_gap_d[W];
      sref_neg_q <= ref_gap_d[W];
      degen_q    <= (raw_hi_q == raw_lo_q);
    end
  end

  // pipeline advances unless the skid register is holding a result
  logic sk_vld_q;
  logic en;

  assign en       = !sk_vld_q;
  assign in_i.ready = en;

  // stage a: sample offset from the lower raw point
  logic [W:0]   diff_d, diff_n;
  logic [W-1:0] a_mag_q;
  logic         a_neg_q, a_vld_q;

  always_comb begin
    diff_d = {in_i.raw_sample[W-1], in_i.raw_sample} - {raw_lo_q[W-1], raw_lo_q};
    diff_n = ~diff_d + (W+1)'(1);
  end

  // stage b: magnitude product
  logic [PW-1:0] b_prod_q;
  logic          b_neg_q, b_vld_q;

  // stage c feeds divider step zero
  logic [W-1:0]  dv_rem_q [QW+1];
  logic [QW-1:0] dv_nq_q  [QW+1];
  logic          dv_neg_q [QW+1];
  logic          dv_vld_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      a_vld_q     <= in_i.valid;
      b_vld_q     <= a_vld_q;
      dv_vld_q[0] <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mag_q     <= diff_d[W] ? diff_n[W-1:0] : diff_d[W-1:0];
      a_neg_q     <= diff_d[W];
      b_prod_q    <= a_mag_q * rmag_q;
      b_neg_q     <= a_neg_q ^ sref_neg_q ^ sraw_neg_q;
      // add half the divisor so the truncating divide rounds half away from zero
      dv_nq_q[0]  <= {1'b0, b_prod_q} + QW'(half_q);
      dv_rem_q[0] <= '0;
      dv_neg_q[0] <= b_neg_q;
    end
  end

  // restoring divider, one quotient bit per stage; quotient shifts in as
  // the numerator shifts out
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [W:0] trial_d, sub_d;
    logic       ge_d;

    always_comb begin
      trial_d = {dv_rem_q[k], dv_nq_q[k][QW-1]};
      sub_d   = trial_d - {1'b0, smag_q};
      ge_d    = (trial_d >= {1'b0, smag_q});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k+1] <= ge_d ? sub_d[W-1:0] : trial_d[W-1:0];
        dv_nq_q[k+1]  <= {dv_nq_q[k][QW-2:0], ge_d};
        dv_neg_q[k+1] <= dv_neg_q[k];
      end
    end
  end

  // final stage: apply sign, add lower reference point, check range and degenerate span
  logic [SW-1:0]     flo_ext, qmag_ext, sum_d;
  logic              fits_d;
  tplc_pkg::status_e st_d;
  logic [W-1:0]      f_val_q, sk_val_q;
  tplc_pkg::status_e f_st_q, sk_st_q;
  logic              f_vld_q;

  always_comb begin
    flo_ext  = {{(SW-W){ref_lo_q[W-1]}}, ref_lo_q};
    qmag_ext = {2'b00, dv_nq_q[QW]};
    sum_d    = dv_neg_q[QW] ? (flo_ext - qmag_ext) : (flo_ext + qmag_ext);
    // in range when all bits from the sign position upwards agree
    fits_d   = (&sum_d[SW-1:W-1]) || !(|sum_d[SW-1:W-1]);
    priority if (degen_q) begin
      st_d = tplc_pkg::StDegenerate;
    end else if (!fits_d) begin
      st_d = tplc_pkg::StRange;
    end else begin
      st_d = tplc_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_st_q  <= st_d;
      f_val_q <= (st_d == tplc_pkg::StOk) ? sum_d[W-1:0] : '0;
    end
  end

  // skid register catches the last stage's result when the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_vld_q <= 1'b0;
    end else if (sk_vld_q) begin
      if (out_o.ready) begin
        sk_vld_q <= 1'b0;
      end
    end else if (f_vld_q && !out_o.ready) begin
      sk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_vld_q && f_vld_q && !out_o.ready) begin
      sk_val_q <= f_val_q;
      sk_st_q  <= f_st_q;
    end
  end

  assign out_o.valid            = sk_vld_q || f_vld_q;
  assign out_o.calibrated_value = sk_vld_q ? sk_val_q : f_val_q;
  assign out_o.status           = sk_vld_q ? sk_st_q : f_st_q;

endmodule

@@ sim/two_point_linear_calibration_checker.sv @@
// calibration checker: watches the configuration port and both channels, predicts each result
// and compares it with what the block delivers
// depends on tplc_pkg, tplc_in_if and tplc_out_if
`timescale 1ns / 100ps
module two_point_linear_calibration_checker #(
  parameter int DataWidth = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tplc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataWidth-1:0]         cfg_data_i,
  tplc_in_if                           in_i,
  tplc_out_if                          out_i,
  output int                           mismatch_cnt_o,
  output int                           pending_cnt_o
);
  import tplc_pkg::*;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    status_e                     status;
  } cal_t;

  logic signed [DataWidth-1:0] raw_lo, ref_lo, raw_hi, ref_hi;
  cal_t                        expected_cal_q[$];

  // exact line through the two points, rounded half away from zero
  function automatic cal_t calibrate_sample(input logic signed [DataWidth-1:0] raw);
    logic signed [DataWidth+1:0]   raw_gap, ref_gap, diff;
    logic signed [2*DataWidth+7:0] num, den, q;
    logic [2*DataWidth+7:0]        num_mag, den_mag, q_mag;
    cal_t                          res;
    res.value  = '0;
    res.status = StOk;
    if (raw_hi == raw_lo) begin
      res.status = StDegenerate;
      return res;
    end
    raw_gap  = raw_hi - raw_lo;
    ref_gap  = ref_hi - ref_lo;
    diff     = raw - raw_lo;
    num      = diff * ref_gap;
    den      = raw_gap;
    num_mag  = (num < 0) ? -num : num;
    den_mag  = (den < 0) ? -den : den;
    q_mag    = (num_mag + (den_mag >> 1)) / den_mag;
    q        = ((num < 0) != (den < 0)) ? -$signed(q_mag) : $signed(q_mag);
    q        = q + ref_lo;
    // fits only if sign extension of the low bits gives it back
    if (q != $signed(q[DataWidth-1:0])) begin
      res.status = StRange;
      return res;
    end
    res.value = q[DataWidth-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cal_t exp_res;
    int   err_cnt;
    if (!rst_ni) begin
      raw_lo         <= '0;
      ref_lo         <= '0;
      raw_hi         <= DataWidth'(1);
      ref_hi         <= DataWidth'(1);
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
      expected_cal_q.delete();
    end else begin
      err_cnt = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRawLo: raw_lo <= cfg_data_i;
          CfgRefLo: ref_lo <= cfg_data_i;
          CfgRawHi: raw_hi <= cfg_data_i;
          CfgRefHi: ref_hi <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        expected_cal_q.push_back(calibrate_sample(in_i.raw_sample));
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_cal_q.size() == 0) begin
          $display("%0t: unexpected result, value %0d status %0d", $time,
                   out_i.calibrated_value, out_i.status);
          err_cnt++;
        end else begin
          exp_res = expected_cal_q.pop_front();
          if (out_i.calibrated_value !== exp_res.value) begin
            $display("%0t: calibrated_value mismatch, expected %0d, actual %0d", $time,
                     exp_res.value, out_i.calibrated_value);
            err_cnt++;
          end
          if (out_i.status !== exp_res.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     exp_res.status, out_i.status);
            err_cnt++;
          end
        end
      end
      mismatch_cnt_o <= mismatch_cnt_o + err_cnt;
      pending_cnt_o  <= expected_cal_q.size();
    end
  end

endmodule

@@ sim/two_point_linear_calibration_top_tb.sv @@
// testbench top: drives samples, calibration points and back-pressure, gives the verdict
// depends on tplc_pkg, the channel interfaces, the block and the calibration checker
`timescale 1ns / 100ps
module two_point_linear_calibration_top_tb;
  import tplc_pkg::*;

  localparam int DataWidth   = 32;
  localparam int Latency     = 2 * DataWidth + 5;
  localparam int HoldCycles  = 4 * Latency;
  localparam int RandPhases  = 17;
  localparam int PhaseItems  = 100;
  localparam int CycleLimit  = 200000;

  localparam logic signed [DataWidth-1:0] MaxWord = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] MinWord = {1'b1, {(DataWidth-1){1'b0}}};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [DataWidth-1:0]   cfg_data_i;
  int                     mismatch_cnt;
  int                     pending_cnt;
  int                     cycle_cnt;
  bit                     idle_on;
  bit                     hold_req;

  tplc_in_if  #(.DataWidth(DataWidth)) in_ch ();
  tplc_out_if #(.DataWidth(DataWidth)) out_ch ();

  two_point_linear_calibration_top #(
    .DATA_WIDTH(DataWidth)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  two_point_linear_calibration_checker #(
    .DataWidth(DataWidth)
  ) u_calib_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on demand
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else if (idle_on && rst_ni && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= rst_ni;
      end
    end
  end

  function automatic logic signed [DataWidth-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4:          return MinWord;
      5:          return MaxWord;
      6:          return '0;
      default:    return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // uniform sample between two points, either order
  function automatic logic signed [DataWidth-1:0] sample_between(
    input logic signed [DataWidth-1:0] a,
    input logic signed [DataWidth-1:0] b
  );
    longint          lo, hi;
    longint unsigned span;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    span = hi - lo + 1;
    return DataWidth'(lo + longint'({$urandom, $urandom} % span));
  endfunction

  // returns at the edge where the request is taken
  task automatic send_sample(input logic signed [DataWidth-1:0] raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_sample <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  task automatic load_points(
    input logic signed [DataWidth-1:0] rlo,
    input logic signed [DataWidth-1:0] flo,
    input logic signed [DataWidth-1:0] rhi,
    input logic signed [DataWidth-1:0] fhi
  );
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgRawLo;
    cfg_data_i <= rlo;
    @(posedge clk_i);
    cfg_idx_i <= CfgRefLo;
    cfg_data_i <= flo;
    @(posedge clk_i);
    cfg_idx_i <= CfgRawHi;
    cfg_data_i <= rhi;
    @(posedge clk_i);
    cfg_idx_i <= CfgRefHi;
    cfg_data_i <= fhi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic signed [DataWidth-1:0] rlo, flo, rhi, fhi, raw;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CfgRawLo;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.raw_sample = '0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // points after reset give the identity line
    send_sample(MinWord);
    send_sample(MaxWord);
    send_sample('0);
    send_sample(DataWidth'(1));
    send_sample(-1);
    send_sample($urandom);
    in_ch.valid <= 1'b0;

    // degenerate raw span
    wait_drained();
    load_points(MaxWord, 123, MaxWord, -5);
    send_sample('0);
    send_sample(MaxWord);
    in_ch.valid <= 1'b0;

    // half-way cases round away from zero
    wait_drained();
    load_points('0, '0, 2, 1);
    send_sample(1);
    send_sample(-1);
    send_sample(3);
    send_sample(-3);
    send_sample('0);
    in_ch.valid <= 1'b0;

    // steepest line: widest product, out of range at the far end
    wait_drained();
    load_points(MinWord, MinWord, MinWord + 1, MaxWord);
    send_sample(MaxWord);
    send_sample(MinWord);
    send_sample(MinWord + 1);
    send_sample(MinWord + 2);
    in_ch.valid <= 1'b0;

    // full-scale falling line
    wait_drained();
    load_points(MinWord, MaxWord, MaxWord, MinWord);
    send_sample(MinWord);
    send_sample(MaxWord);
    send_sample('0);
    in_ch.valid <= 1'b0;

    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_drained();
      rlo = pick_word();
      flo = pick_word();
      rhi = pick_word();
      fhi = pick_word();
      if ($urandom_range(0, 9) == 0) rhi = rlo;
      load_points(rlo, flo, rhi, fhi);
      idle_on = (ph < RandPhases - 3);
      // long hold-off on the result side so the pipeline backs up
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(0, 3))
          0, 1:    raw = sample_between(rlo, rhi);
          2:       raw = pick_word();
          default: raw = $urandom;
        endcase
        send_sample(raw);
      end
      in_ch.valid <= 1'b0;
    end

    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
